// ===== hdl/pil_pkg.sv =====
package pil_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 16;
	localparam int DEPTH_DEF = 64;

	// func field codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// status field codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// broadcast command from control to every cell
	typedef struct packed {
		logic shift_in;   // insert: open a slot at pos, shift the tail right
		logic rotate;     // read-out: rotate the occupied part left by one
	} cell_cmd_t;

endpackage

// ===== hdl/positional_insert_list_unit.sv =====
// Positional insert list: an ordered sequence of up to DEPTH signed 32-bit values.
// Input channel (in_valid/in_ready) carries func, position, value.
//   func = insert: value lands at index position; a position at or past the
//   current count appends. Gives no result, unless the list is full, in
//   which case one status=full result is given.
//   func = read: every stored value goes out in order, one transfer per cycle
//   while the receiver is ready, last marking the final one; the list is
//   unchanged. An empty list gives one transfer with status=empty and last set.
// Output channel (out_valid/out_ready) carries data_out, last, status from a
// register: a full or empty status result shows in the cycle after the input
// transfer; the first read-out value passes S_READ, then the output register.
// Inserts are taken one per cycle while the output register is free; a read-out
// holds the input until all its values are sent. Storage is a row of cells that
// all shift together: an insert shifts the tail right, a read-out rotates the
// occupied part left so the head cell feeds the output and the list is back in
// order once every value is out. A new item is taken only while no read-out is
// running and the output register is free or being drained. A stalled receiver
// simply holds the read-out; nothing is lost. Reset (arst_n low) empties the list.
module positional_insert_list_unit #(
	parameter int DEPTH = pil_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [pil_pkg::POS_W-1:0]         position,
	input  logic signed [pil_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pil_pkg::DATA_W-1:0] data_out,
	output logic                              last,
	output logic [1:0]                        status
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t                            state_q;
	logic [CW-1:0]                     count_q;
	logic [IW-1:0]                     rd_idx_q;
	logic                              out_valid_q;
	logic signed [pil_pkg::DATA_W-1:0] data_q;
	logic                              last_q;
	logic [1:0]                        status_q;

	logic                              out_free;
	logic                              accept;
	logic                              full;
	logic                              ins_ok;
	logic                              rd_step;
	logic                              rd_last;
	logic [IW-1:0]                     pos_eff;
	logic [IW-1:0]                     last_idx;
	pil_pkg::cell_cmd_t                cmd;
	logic signed [pil_pkg::DATA_W-1:0] cell_data [DEPTH];
	logic signed [pil_pkg::DATA_W-1:0] left_d    [DEPTH];
	logic signed [pil_pkg::DATA_W-1:0] right_d   [DEPTH];

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == FULL_CNT);
	assign ins_ok   = accept && (func == pil_pkg::FUNC_INSERT) && !full;
	assign rd_step  = (state_q == S_READ) && out_free;

	// clamp position to count (append); only used when not full, so fits IW bits
	always_comb begin
		if (32'(position) >= 32'(count_q)) begin
			pos_eff = IW'(count_q);
		end else begin
			pos_eff = IW'(position);
		end
	end

	assign last_idx     = IW'(count_q - CW'(1));
	assign rd_last      = (rd_idx_q == last_idx);
	assign cmd.shift_in = ins_ok;
	assign cmd.rotate   = rd_step;

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_d[i] = value;
		end else begin : g_mid_l
			assign left_d[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_lastc
			assign right_d[i] = cell_data[0];
		end else begin : g_mid_r
			assign right_d[i] = cell_data[i+1];
		end

		pil_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.pos        (pos_eff),
			.last_idx   (last_idx),
			.value      (value),
			.left_data  (left_d[i]),
			.right_data (right_d[i]),
			.head_data  (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	// control: state, count, read index, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == pil_pkg::FUNC_INSERT) begin
							if (full) begin
								out_valid_q <= 1'b1;
							end else begin
								count_q     <= count_q + CW'(1);
								out_valid_q <= out_valid_q && !out_ready;
							end
						end else if (count_q == '0) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q     <= S_READ;
							rd_idx_q    <= '0;
							out_valid_q <= out_valid_q && !out_ready;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					if (rd_step) begin
						out_valid_q <= 1'b1;
						rd_idx_q    <= rd_idx_q + IW'(1);
						if (rd_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (rd_step) begin
			data_q   <= cell_data[0];
			last_q   <= rd_last;
			status_q <= pil_pkg::ST_OK;
		end else if (accept && (func == pil_pkg::FUNC_INSERT) && full) begin
			data_q   <= '0;
			last_q   <= 1'b0;
			status_q <= pil_pkg::ST_FULL;
		end else if (accept && (func == pil_pkg::FUNC_READ) && (count_q == '0)) begin
			data_q   <= '0;
			last_q   <= 1'b1;
			status_q <= pil_pkg::ST_EMPTY;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign last      = last_q;
	assign status    = status_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("count beyond depth");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (count_q != '0))
		else $error("read-out running on empty list");

	a_rd_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (rd_idx_q <= last_idx))
		else $error("read index past end of list");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not bump count");

	a_last_ends_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (state_q == S_IDLE))
		else $error("last shown while read-out still running");

endmodule

// ===== hdl/pil_cell.sv =====
module pil_cell #(
	parameter int DEPTH = pil_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                             clk,
	input  pil_pkg::cell_cmd_t               cmd,
	input  logic [$clog2(DEPTH)-1:0]         pos,
	input  logic [$clog2(DEPTH)-1:0]         last_idx,
	input  logic signed [pil_pkg::DATA_W-1:0] value,
	input  logic signed [pil_pkg::DATA_W-1:0] left_data,
	input  logic signed [pil_pkg::DATA_W-1:0] right_data,
	input  logic signed [pil_pkg::DATA_W-1:0] head_data,
	output logic signed [pil_pkg::DATA_W-1:0] data
);

	localparam int IW = $clog2(DEPTH);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [pil_pkg::DATA_W-1:0] data_q;

	// cells past the occupied part may pick up junk; never read
	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			if (MY_IDX == pos) begin
				data_q <= value;
			end else if (MY_IDX > pos) begin
				data_q <= left_data;
			end
		end else if (cmd.rotate) begin
			if (MY_IDX == last_idx) begin
				data_q <= head_data;
			end else begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;

endmodule

// ===== verif/tb.sv =====
module tb;

	localparam int LIST_DEPTH  = pil_pkg::DEPTH_DEF;
	localparam int POS_W       = pil_pkg::POS_W;
	localparam int DATA_W      = pil_pkg::DATA_W;
	// cycles the output side may still need after the last expected transfer
	localparam int SETTLE_CYC  = 20;
	// run limit in clock cycles, far above the slowest correct run
	localparam int LIMIT_CYC   = 300000;
	// percent of cycles in which each side idles
	localparam int IDLE_PCT    = 36;

	// one pending input item; hold marks a pause until all results are back,
	// calm marks items driven with no idling on either side
	typedef struct {
		logic                     hold;
		logic                     calm;
		logic                     func;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} list_op_t;

	// one expected output transfer
	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic                     last;
		logic [1:0]               status;
	} list_word_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     func;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] data_out;
	logic                     last;
	logic [1:0]               status;

	positional_insert_list_unit #(
		.DEPTH(LIST_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.position (position),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_out (data_out),
		.last     (last),
		.status   (status)
	);

	// items waiting to be driven, filled up front by the stimulus block
	list_op_t   op_queue[$];
	// words the list must still emit, oldest first
	list_word_t readout_q[$];

	// shadow of the stored sequence
	logic signed [DATA_W-1:0] seq_cells[LIST_DEPTH];
	int                       seq_count;

	logic in_taken;    // input transfer happened at the last rising edge
	logic calm_mode;   // current item is in the no-idle stretch
	int   fails;
	int   reported;
	int   gen_count;   // list length as seen while generating stimulus

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out what an accepted item must produce and update the shadow list.
	// Inserts shift the tail right; a position past the end appends.
	task automatic apply_to_list(input logic f, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		int         p;
		list_word_t w;
		if (f == pil_pkg::FUNC_INSERT) begin
			if (seq_count >= LIST_DEPTH) begin
				w.data   = '0;
				w.last   = 1'b0;
				w.status = pil_pkg::ST_FULL;
				readout_q.push_back(w);
			end else begin
				p = (int'(pos) > seq_count) ? seq_count : int'(pos);
				for (int i = seq_count; i > p; i--)
					seq_cells[i] = seq_cells[i - 1];
				seq_cells[p] = val;
				seq_count++;
			end
		end else if (seq_count == 0) begin
			w.data   = '0;
			w.last   = 1'b1;
			w.status = pil_pkg::ST_EMPTY;
			readout_q.push_back(w);
		end else begin
			for (int i = 0; i < seq_count; i++) begin
				w.data   = seq_cells[i];
				w.last   = (i == seq_count - 1);
				w.status = pil_pkg::ST_OK;
				readout_q.push_back(w);
			end
		end
	endtask

	task automatic queue_op(input logic f, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val, input logic calm);
		list_op_t op;
		op.hold     = 1'b0;
		op.calm     = calm;
		op.func     = f;
		op.position = pos;
		op.value    = val;
		op_queue.push_back(op);
		if (f == pil_pkg::FUNC_INSERT && gen_count < LIST_DEPTH)
			gen_count++;
	endtask

	task automatic queue_hold();
		list_op_t op;
		op.hold     = 1'b1;
		op.calm     = 1'b0;
		op.func     = pil_pkg::FUNC_READ;
		op.position = '0;
		op.value    = '0;
		op_queue.push_back(op);
	endtask

	// Random insert position: head, exact end, just before the end, anywhere
	// inside, or far past the end so that it appends.
	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return POS_W'(gen_count);
			2: return POS_W'((gen_count > 0) ? gen_count - 1 : 0);
			3: return POS_W'($urandom_range(0, gen_count));
			4: return POS_W'($urandom);
			default: return '1;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return -32'sd1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Driver: changes inputs at the falling edge. A presented item stays until
	// its transfer; hold markers keep valid low until every result is back.
	always @(negedge clk) begin : drive_proc
		list_op_t op;
		logic     next_valid;
		if (arst_n !== 1'b1) begin
			in_valid  <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!(in_valid && !in_taken)) begin
				next_valid = 1'b0;
				if (op_queue.size() > 0) begin
					if (op_queue[0].hold) begin
						if (readout_q.size() == 0)
							void'(op_queue.pop_front());
					end else if (op_queue[0].calm || $urandom_range(0, 99) >= IDLE_PCT) begin
						op = op_queue.pop_front();
						next_valid = 1'b1;
						func      <= op.func;
						position  <= op.position;
						value     <= op.value;
						calm_mode = op.calm;
					end
				end
				in_valid <= next_valid;
			end
			// receiver stalls at random, except in the calm stretch
			out_ready <= calm_mode || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Predictor and monitor, both at the rising edge. Results come from a
	// register, so a transfer never meets the item that causes it.
	always @(posedge clk or negedge arst_n) begin : watch_proc
		list_word_t w;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				apply_to_list(func, position, value);
			if (out_valid && out_ready) begin
				if (readout_q.size() == 0) begin
					fails++;
					if (reported < 10) begin
						reported++;
						$display("unexpected transfer: data=%0d last=%0b status=%0d",
							data_out, last, status);
					end
				end else begin
					w = readout_q.pop_front();
					if (data_out !== w.data || last !== w.last || status !== w.status) begin
						fails++;
						if (reported < 10) begin
							reported++;
							$display({"mismatch: exp data=%0d last=%0b status=%0d,",
								" got data=%0d last=%0b status=%0d"},
								w.data, w.last, w.status, data_out, last, status);
						end
					end
				end
			end
		end
	end

	initial begin : stim_proc
		logic calm;
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		func      = pil_pkg::FUNC_INSERT;
		position  = '0;
		value     = '0;
		calm_mode = 1'b0;
		seq_count = 0;
		fails     = 0;
		reported  = 0;
		gen_count = 0;

		// directed: empty read, extremes, head and middle inserts, appends
		queue_op(pil_pkg::FUNC_READ,   16'h0000, 32'sh0000_0000, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h0000, 32'sh7FFF_FFFF, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'hFFFF, 32'sh8000_0000, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h0000, -32'sd1,        1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h0001, 32'sh0000_0000, 1'b0);
		queue_op(pil_pkg::FUNC_READ,   16'h0000, 32'sh0000_0000, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h0004, 32'sh0000_0001, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h5555, 32'sh5555_5555, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h0002, 32'shAAAA_AAAA, 1'b0);
		// read-out ignores position and value
		queue_op(pil_pkg::FUNC_READ,   16'hFFFF, 32'shFFFF_FFFF, 1'b0);
		queue_hold();
		queue_op(pil_pkg::FUNC_READ,   16'hAAAA, 32'sh1234_5678, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h0006, 32'sd123,       1'b0);
		queue_op(pil_pkg::FUNC_READ,   16'h0000, 32'sh0000_0000, 1'b0);

		// random: inserts slightly outnumber reads so the list fills late
		for (int n = 0; n < 140; n++) begin
			calm = (n >= 50 && n < 90);
			if (n % 40 == 39)
				queue_hold();
			if ($urandom_range(0, 99) < 55)
				queue_op(pil_pkg::FUNC_INSERT, pick_position(), pick_value(), calm);
			else
				queue_op(pil_pkg::FUNC_READ, POS_W'($urandom), pick_value(), calm);
		end

		// fill to the top, then hit the full case and read the full list
		while (gen_count < LIST_DEPTH)
			queue_op(pil_pkg::FUNC_INSERT, pick_position(), pick_value(), 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'h0000, 32'sh7FFF_FFFF, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, 16'hFFFF, 32'sh8000_0000, 1'b0);
		queue_op(pil_pkg::FUNC_READ,   16'h0000, 32'sh0000_0000, 1'b0);
		queue_op(pil_pkg::FUNC_INSERT, POS_W'($urandom), pick_value(), 1'b0);
		queue_op(pil_pkg::FUNC_READ,   16'hFFFF, 32'shFFFF_FFFF, 1'b0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		if (fails == 0 && readout_q.size() == 0)
			$display("positional_insert_list_unit verification clean");
		else
			$display("positional_insert_list_unit verification failed");
		$finish;
	end

	initial begin : limit_proc
		#(8 * LIMIT_CYC);
		$display("positional_insert_list_unit verification failed");
		$finish;
	end

endmodule
